@@ design/sms_pkg.sv @@
// Package for the sorted multiset store: operation codes, transaction
// structs and the link struct passed along the row of cells. No dependencies.
package sms_pkg;

  // Default number of cells in the row.
  localparam int unsigned CAPACITY_DEF = 64;

  // Width of one stored value.
  localparam int unsigned VAL_W = 32;

  // Width of the reported element count.
  localparam int unsigned CNT_OUT_W = 7;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } sms_op_t;

  // Input transaction.
  typedef struct packed {
    sms_op_t                   operation;
    logic signed [VAL_W-1:0]   value;
  } sms_in_t;

  // Result transaction.
  typedef struct packed {
    logic                      found;
    logic                      dropped;
    logic [CNT_OUT_W-1:0]      element_count;
    logic                      empty_res;
    logic signed [VAL_W-1:0]   smallest;
    logic signed [VAL_W-1:0]   largest;
  } sms_out_t;

  // What one cell hands to its upper neighbour.
  typedef struct packed {
    logic                      occ;
    logic                      gt;
    logic signed [VAL_W-1:0]   val;
  } sms_link_t;

endpackage

@@ design/sms_cell.sv @@
// One cell of the sorted row: holds a single value and shifts or loads it
// on an insert. Depends on sms_pkg.
module sms_cell (
  input  logic                                clk,
  input  logic                                ins_en,
  input  logic                                occ,
  input  logic signed [sms_pkg::VAL_W-1:0]    key,
  input  sms_pkg::sms_link_t                  prev,
  output sms_pkg::sms_link_t                  link,
  output logic                                match
);

  logic signed [sms_pkg::VAL_W-1:0] val_r;
  logic signed [sms_pkg::VAL_W-1:0] val_nxt;
  logic                             gt;

  // Compare the held value against the key.
  assign gt    = occ && (val_r > key);
  assign match = occ && (val_r == key);

  assign link.occ = occ;
  assign link.gt  = gt;
  assign link.val = val_r;

  // An occupied cell above the key takes its neighbour's value, or the key
  // if it is the insertion point. The first free cell takes whatever the
  // neighbour pushes up, or the key when nothing is pushed.
  always_comb begin
    val_nxt = val_r;
    if (ins_en) begin
      if (occ) begin
        if (gt) begin
          val_nxt = prev.gt ? prev.val : key;
        end
      end else if (prev.gt) begin
        val_nxt = prev.val;
      end else if (prev.occ) begin
        val_nxt = key;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

@@ design/sorted_multiset_store_unit.sv @@
// Sorted multiset store: a row of CAPACITY cells kept in ascending order.
// Results are registered. All cells compare and shift at once. Throughput:
// one transaction per cycle, except while a result is held back by out_stall.
// Reset clears the fill count and the result valid; cell contents are left
// undefined and only occupied cells are ever read. Depends on sms_pkg, sms_cell.
module sorted_multiset_store_unit #(
  parameter int unsigned CAPACITY = sms_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sms_pkg::sms_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sms_pkg::sms_out_t out_data
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]                  count_r;
  logic [CNT_W-1:0]                  count_nxt;
  logic signed [sms_pkg::VAL_W-1:0]  largest_r;
  logic signed [sms_pkg::VAL_W-1:0]  largest_nxt;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  sms_pkg::sms_out_t                 out_data_r;
  sms_pkg::sms_out_t                 out_data_nxt;

  logic                              accept;
  logic                              full;
  logic                              is_insert;
  logic                              ins_en;
  logic signed [sms_pkg::VAL_W-1:0]  key;
  logic signed [sms_pkg::VAL_W-1:0]  smallest_nxt;
  logic [CAPACITY-1:0]               match;
  sms_pkg::sms_link_t                link [CAPACITY+1];

  // Handshake: a new transaction goes in unless a result is held back.
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign key       = in_data.value;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign is_insert = (in_data.operation == sms_pkg::OP_INSERT);
  assign ins_en    = accept && is_insert && !full;

  // Below the first cell sits an occupied boundary that is never greater.
  assign link[0].occ = 1'b1;
  assign link[0].gt  = 1'b0;
  assign link[0].val = '0;

  // The row of cells.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    sms_cell u_cell (
      .clk    (clk),
      .ins_en (ins_en),
      .occ    (count_r > CNT_W'(g)),
      .key    (key),
      .prev   (link[g]),
      .link   (link[g+1]),
      .match  (match[g])
    );
  end

  // New count, extremes and the result for this transaction.
  always_comb begin
    count_nxt    = count_r;
    largest_nxt  = largest_r;
    smallest_nxt = link[1].val;
    if (ins_en) begin
      count_nxt = count_r + CNT_W'(1);
      if (count_r == '0 || key >= largest_r) begin
        largest_nxt = key;
      end
      if (count_r == '0 || key < link[1].val) begin
        smallest_nxt = key;
      end
    end
  end

  always_comb begin
    out_data_nxt               = out_data_r;
    out_valid_nxt              = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.found         = !is_insert && (|match);
      out_data_nxt.dropped       = is_insert && full;
      out_data_nxt.element_count = sms_pkg::CNT_OUT_W'(count_nxt);
      out_data_nxt.empty_res     = (count_nxt == '0);
      out_data_nxt.smallest      = (count_nxt == '0) ? '0 : smallest_nxt;
      out_data_nxt.largest       = (count_nxt == '0) ? '0 : largest_nxt;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    largest_r  <= largest_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  // The count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // An insert into a full store is reported as dropped.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_insert && full) |=> (out_valid && out_data.dropped))
    else $error("insert into full store not dropped");

  // An empty result shows zero extremes.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.empty_res) |-> (out_data.smallest == '0 &&
      out_data.largest == '0 && out_data.element_count == '0))
    else $error("empty result with non-zero fields");

  // The two lowest occupied cells stay in order.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    link[2].occ |-> (link[1].val <= link[2].val))
    else $error("cells out of order");
`endif

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for sorted_multiset_store_unit: random and directed
// insert and query transactions, checked against a queue-based sorted store.
// Depends on sms_pkg and the sorted_multiset_store_unit RTL.
module tb;

  localparam int unsigned STORE_DEPTH = sms_pkg::CAPACITY_DEF;
  localparam int unsigned RANDOM_ITEMS = 1030;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned LONG_HOLD = 150;
  localparam int unsigned MAX_REPORTS = 10;

  // One queued input transaction; hold_for_drain makes the sender wait until
  // every outstanding result has come back before offering it.
  typedef struct {
    sms_pkg::sms_in_t item;
    bit               hold_for_drain;
  } pending_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  sms_pkg::sms_in_t   in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sms_pkg::sms_out_t  out_data;

  pending_item_t      pending_q[$];
  sms_pkg::sms_out_t  expected_q[$];
  int                 store_vals[$];
  int                 gen_inserted[$];

  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned next_hold_at = 300;
  int unsigned n_sent = 0;
  int unsigned n_done = 0;
  int unsigned n_fail = 0;
  int unsigned idle_cycles = 0;
  sms_pkg::sms_out_t exp_res;

  sorted_multiset_store_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // Sorted store: applies one transaction and returns the result it yields.
  function automatic sms_pkg::sms_out_t apply_to_store(sms_pkg::sms_in_t t);
    sms_pkg::sms_out_t r;
    int                pos;
    int                v;
    r = '0;
    v = t.value;
    if (t.operation == sms_pkg::OP_INSERT) begin
      if (store_vals.size() >= STORE_DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        pos = store_vals.size();
        while (pos > 0 && store_vals[pos-1] > v) pos--;
        store_vals.insert(pos, v);
      end
    end else begin
      foreach (store_vals[k]) if (store_vals[k] == v) r.found = 1'b1;
    end
    r.element_count = sms_pkg::CNT_OUT_W'(store_vals.size());
    r.empty_res = (store_vals.size() == 0);
    if (!r.empty_res) begin
      r.smallest = store_vals[0];
      r.largest = store_vals[store_vals.size()-1];
    end
    return r;
  endfunction

  // Gap after a transaction: mostly none or short, now and then long.
  // Every third block of a hundred transactions runs without gaps.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if ((n_sent / 100) % 3 == 1) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Value mix: full range, a narrow band for duplicates, extremes, and values
  // already inserted so that queries often hit.
  function automatic int pick_value();
    int unsigned r;
    int          edge_vals[7];
    edge_vals = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1, 32'sh8000_0001, 32'sh7fff_fffe};
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom;
    if (r < 50) return $signed($urandom_range(0, 16)) - 8;
    if (r < 58) return edge_vals[$urandom_range(0, 6)];
    if (gen_inserted.size() != 0) return gen_inserted[$urandom_range(0, gen_inserted.size()-1)];
    return $urandom;
  endfunction

  task automatic add_item(sms_pkg::sms_op_t op, int v, bit drain);
    pending_item_t p;
    p.item.operation = op;
    p.item.value = v;
    p.hold_for_drain = drain;
    if (op == sms_pkg::OP_INSERT) gen_inserted.push_back(v);
    pending_q.push_back(p);
  endtask

  task automatic report_failure(string what, sms_pkg::sms_out_t want,
                                sms_pkg::sms_out_t got);
    n_fail++;
    if (n_fail <= MAX_REPORTS) begin
      $display("%0t %s: exp found=%b dropped=%b count=%0d empty=%b min=%0d max=%0d",
               $time, what, want.found, want.dropped, want.element_count, want.empty_res,
               want.smallest, want.largest);
      $display("%0t %s: got found=%b dropped=%b count=%0d empty=%b min=%0d max=%0d",
               $time, what, got.found, got.dropped, got.element_count, got.empty_res,
               got.smallest, got.largest);
    end
  endtask

  // Driver: records each accepted transaction in the store and offers the next.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(apply_to_store(in_data));
        n_sent <= n_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_q.size() != 0 &&
                     (!pending_q[0].hold_for_drain || (!in_valid && n_sent == n_done))) begin
          in_valid <= 1'b1;
          in_data <= pending_q[0].item;
          void'(pending_q.pop_front());
          gap_left <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, with a long hold-off every few hundred results.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (n_done >= next_hold_at) begin
      out_stall <= 1'b1;
      stall_left <= LONG_HOLD;
      next_hold_at <= next_hold_at + 400;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ((n_done / 100) % 3 == 2) begin
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:54]: begin
          out_stall <= 1'b0;
          stall_left <= $urandom_range(0, 4);
        end
        [55:89]: begin
          out_stall <= 1'b1;
          stall_left <= $urandom_range(0, 2);
        end
        [90:97]: begin
          out_stall <= 1'b1;
          stall_left <= $urandom_range(4, 12);
        end
        default: begin
          out_stall <= 1'b1;
          stall_left <= $urandom_range(20, 50);
        end
      endcase
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_done <= n_done + 1;
      if (expected_q.size() == 0) begin
        report_failure("unexpected result", '0, out_data);
      end else begin
        exp_res = expected_q.pop_front();
        if (out_data.found !== exp_res.found || out_data.dropped !== exp_res.dropped ||
            out_data.element_count !== exp_res.element_count ||
            out_data.empty_res !== exp_res.empty_res ||
            out_data.smallest !== exp_res.smallest || out_data.largest !== exp_res.largest)
          report_failure("result mismatch", exp_res, out_data);
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    // Empty store, extremes, duplicates, hits and misses.
    add_item(sms_pkg::OP_QUERY, 0, 1'b0);
    add_item(sms_pkg::OP_QUERY, 32'sh8000_0000, 1'b0);
    add_item(sms_pkg::OP_INSERT, 0, 1'b0);
    add_item(sms_pkg::OP_INSERT, 0, 1'b0);
    add_item(sms_pkg::OP_QUERY, 0, 1'b0);
    add_item(sms_pkg::OP_INSERT, 32'sh8000_0000, 1'b0);
    add_item(sms_pkg::OP_INSERT, 32'sh7fff_ffff, 1'b0);
    add_item(sms_pkg::OP_QUERY, 32'sh7fff_ffff, 1'b0);
    add_item(sms_pkg::OP_QUERY, 32'sh8000_0000, 1'b0);
    add_item(sms_pkg::OP_INSERT, -1, 1'b0);
    add_item(sms_pkg::OP_INSERT, 1, 1'b0);
    add_item(sms_pkg::OP_QUERY, -1, 1'b0);
    add_item(sms_pkg::OP_QUERY, 2, 1'b0);
    add_item(sms_pkg::OP_QUERY, 32'sh7fff_fffe, 1'b0);
    add_item(sms_pkg::OP_INSERT, 32'sh7fff_ffff, 1'b0);
    add_item(sms_pkg::OP_INSERT, 32'sh8000_0000, 1'b0);
    add_item(sms_pkg::OP_INSERT, 0, 1'b0);
    add_item(sms_pkg::OP_QUERY, 32'sh5555_5555, 1'b0);
    add_item(sms_pkg::OP_QUERY, 32'shaaaa_aaaa, 1'b0);

    // Random part: inserts are sparse so the store fills about halfway through
    // and later inserts are dropped. A few transactions wait for a full drain.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      add_item(($urandom_range(0, 7) == 0) ? sms_pkg::OP_INSERT : sms_pkg::OP_QUERY,
               pick_value(), (i == 250 || i == 600 || i == 900));
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (n_fail == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
